@@ design/aabb_pkg.sv @@
package aabb_pkg;

  localparam int PosW = 24;
  localparam int SizeW = 20;
  localparam int CfgW = 23;
  // Intermediate geometry width: sums of positions, sizes and moves.
  localparam int GeoW = 28;

  localparam logic [1:0] CfgTimeStep = 2'd0;
  localparam logic [1:0] CfgGravity  = 2'd1;
  localparam logic [1:0] CfgMapW     = 2'd2;
  localparam logic [1:0] CfgMapH     = 2'd3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  localparam logic signed [GeoW-1:0] VyFloor = -28'sd384000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_SCANX,
    ST_RESX,
    ST_MULG,
    ST_MULGT,
    ST_GRAV,
    ST_MULY,
    ST_SCANY,
    ST_RESY,
    ST_OUT
  } aabb_state_t;

  // Scan request from the sequencer to the table scanner.
  typedef struct packed {
    logic                   start;
    logic                   axis_y;
    logic                   dir_pos;
    logic                   dir_neg;
  } aabb_scan_req_t;

  // Per-axis query geometry.
  typedef struct packed {
    logic signed [GeoW-1:0] lo;
    logic signed [GeoW-1:0] size;
    logic signed [GeoW-1:0] cross_lo;
    logic signed [GeoW-1:0] cross_size;
    logic signed [GeoW-1:0] lead;
  } aabb_query_t;

  typedef struct packed {
    logic                   done;
    logic                   found;
    logic signed [GeoW-1:0] stop;
  } aabb_scan_rsp_t;

  function automatic logic signed [GeoW-1:0] floor_shr16(
    input logic signed [2*GeoW-1:0] v);
    floor_shr16 = GeoW'(v >>> 16);
  endfunction

endpackage

@@ design/aabb_scan.sv @@
module aabb_scan #(
  parameter int MAX_BOXES = 64,
  parameter int IDX_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic                       wr_keep,
  input  logic signed [23:0]         wr_x,
  input  logic signed [23:0]         wr_y,
  input  logic [19:0]                wr_w,
  input  logic [19:0]                wr_h,
  input  logic [6:0]                 skip_slot,
  input  aabb_pkg::aabb_scan_req_t   req,
  input  aabb_pkg::aabb_query_t      qry,
  output aabb_pkg::aabb_scan_rsp_t   rsp
);
  import aabb_pkg::*;

  logic [PosW+PosW+SizeW+SizeW-1:0] mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] valid_r;
  logic [PosW+PosW+SizeW+SizeW-1:0] rd_r;
  logic [IDX_W:0] idx_r, idx_nxt;
  logic [IDX_W:0] rd_idx_r;
  logic busy_r, busy_nxt, rd_v_r, rd_v_nxt;
  logic axis_r, pos_r, neg_r;
  logic found_r, found_nxt;
  logic signed [GeoW-1:0] stop_r, stop_nxt;
  logic done_r, done_nxt;

  logic signed [GeoW-1:0] ox, oy, ow, oh, a_lo, a_sz, c_lo, c_sz;
  logic ent_ok, overlap;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_x, wr_y, wr_w, wr_h};
    end
    rd_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= wr_keep;
    end
  end

  always_comb begin
    ow = $signed({{(GeoW-SizeW){1'b0}}, rd_r[39:20]});
    oh = $signed({{(GeoW-SizeW){1'b0}}, rd_r[19:0]});
    ox = $signed({{(GeoW-PosW){rd_r[87]}}, rd_r[87:64]});
    oy = $signed({{(GeoW-PosW){rd_r[63]}}, rd_r[63:40]});
    a_lo = axis_r ? oy : ox;
    a_sz = axis_r ? oh : ow;
    c_lo = axis_r ? ox : oy;
    c_sz = axis_r ? ow : oh;
    ent_ok = valid_r[rd_idx_r[IDX_W-1:0]] && (32'(rd_idx_r) != 32'(skip_slot));
    overlap = (qry.cross_lo + qry.cross_size > c_lo) && (qry.cross_lo < c_lo + c_sz);
  end

  always_comb begin
    idx_nxt = idx_r;
    busy_nxt = busy_r;
    rd_v_nxt = 1'b0;
    found_nxt = found_r;
    stop_nxt = stop_r;
    done_nxt = 1'b0;
    if (req.start) begin
      idx_nxt = '0;
      busy_nxt = 1'b1;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      rd_v_nxt = 1'b1;
      if (idx_r == (IDX_W+1)'(MAX_BOXES - 1)) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + 1'b1;
    end
    if (rd_v_r && ent_ok && overlap) begin
      if (pos_r && qry.lead <= a_lo) begin
        if (!found_r || a_lo < stop_r) stop_nxt = a_lo;
        found_nxt = 1'b1;
      end else if (neg_r && (axis_r ? qry.lo >= a_lo : qry.lo >= a_lo + a_sz)) begin
        if (!found_r || a_lo + a_sz > stop_r) stop_nxt = a_lo + a_sz;
        found_nxt = 1'b1;
      end
    end
    if (rd_v_r && !rd_v_nxt && !busy_r) done_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rd_v_r <= 1'b0;
      done_r <= 1'b0;
      idx_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      rd_v_r <= rd_v_nxt;
      done_r <= done_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    found_r <= found_nxt;
    stop_r <= stop_nxt;
    if (req.start) begin
      axis_r <= req.axis_y;
      pos_r <= req.dir_pos;
      neg_r <= req.dir_neg;
    end
  end

  assign rsp.done = done_r;
  assign rsp.found = found_r;
  assign rsp.stop = stop_r;

  a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(rd_v_r)) else $error("scan done without read");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("scan did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("scan done while busy");

endmodule

@@ design/aabb_sweep_collision_step.sv @@
// Swept box collision step.
// Input channel in_*: one transaction per item. opcode 0 loads an obstacle
// slot of the internal table; opcode 1 runs one physics step for a moving
// box and produces exactly one result transaction on out_*.
// Configuration writes (time step, gravity, map size) go through cfg_* and
// must be issued only while the block is idle with no result pending.
// A load is written at its accepting edge, and the next item can be taken
// in the following cycle. A step's result waits on the two scans of the
// obstacle table through its single read port and on the one shared 28x28
// multiplier, used four times in sequence. With a ready receiver the next
// item is accepted once the result has been taken.
// in_tready is low while an item is at work and while a result waits.
// When the receiver stalls, the result is held in the output register and
// no new item is accepted until it is taken.
// Reset clears the valid bits of all obstacle slots, the configuration
// registers return to their defaults, and the block comes up idle.
module aabb_sweep_collision_step #(
  parameter int MAX_BOXES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode, slot[7], keep, pos_x[24], pos_y[24], box_width[20],
  // box_height[20], vel_x[24], vel_y[24], mass[16], zero pad to 168
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_x[24], new_y[24], new_vel_x[24], new_vel_y[24], airborne,
  // x_stalled, zero pad to 104
  output logic [103:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [22:0]  cfg_wdata
);
  import aabb_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  aabb_state_t state_r, state_nxt;

  logic [15:0] ts_r, grav_r;
  logic [22:0] mapw_r, maph_r;

  // Captured item.
  logic [6:0] slot_r;
  logic signed [GeoW-1:0] px_r, py_r, w_r, h_r, vx_r, vy_r, nx_r;
  logic [15:0] mass_r;
  logic signed [2*GeoW-1:0] prod_r;
  logic signed [GeoW-1:0] dx_r;
  logic signed [GeoW-1:0] dy_r;
  logic signed [GeoW-1:0] vyn_r, ny_r;
  logic signed [GeoW-1:0] vy_c;
  logic airborne_r;
  logic [103:0] out_r;
  logic out_v_r;

  logic ld_en;
  logic signed [GeoW-1:0] mul_a, mul_b;
  aabb_scan_req_t req;
  aabb_query_t qry;
  aabb_scan_rsp_t rsp;

  logic [167:0] d;
  assign d = in_tdata;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !out_v_r;
  assign ld_en = in_acc && (d[0] == OpLoad) && (32'(d[7:1]) < MAX_BOXES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= 16'd1092;
      grav_r <= 16'd2509;
      mapw_r <= 23'd262144;
      maph_r <= 23'd196608;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgTimeStep: ts_r <= cfg_wdata[15:0];
        CfgGravity:  grav_r <= cfg_wdata[15:0];
        CfgMapW:     mapw_r <= cfg_wdata;
        CfgMapH:     maph_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select. The gravity term is taken straight
  // from the product of the previous cycle, floored by the shift.
  always_comb begin
    mul_a = vx_r;
    mul_b = GeoW'(ts_r);
    case (state_r)
      ST_MULX:  begin mul_a = vx_r; mul_b = GeoW'(ts_r); end
      ST_MULG:  begin mul_a = GeoW'(grav_r); mul_b = GeoW'(mass_r); end
      ST_MULGT: begin mul_a = GeoW'(prod_r >>> 8); mul_b = GeoW'(ts_r); end
      ST_MULY, ST_SCANY: begin mul_a = vy_r; mul_b = GeoW'(ts_r); end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && d[0] == OpStep) state_nxt = ST_MULX;
      ST_MULX:  state_nxt = ST_SCANX;
      ST_SCANX: if (rsp.done) state_nxt = ST_RESX;
      ST_RESX:  state_nxt = ST_MULG;
      ST_MULG:  state_nxt = ST_MULGT;
      ST_MULGT: state_nxt = ST_GRAV;
      ST_GRAV:  state_nxt = ST_MULY;
      ST_MULY:  state_nxt = ST_SCANY;
      ST_SCANY: if (rsp.done) state_nxt = ST_RESY;
      ST_RESY:  state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    qry = '0;
    if (state_r == ST_MULX) begin
      req.start = 1'b1;
      req.axis_y = 1'b0;
      req.dir_pos = vx_r > 0;
      req.dir_neg = vx_r < 0;
    end else if (state_r == ST_MULY) begin
      req.start = 1'b1;
      req.axis_y = 1'b1;
      req.dir_pos = vy_r < 0;
      req.dir_neg = vy_r > 0;
    end
    if (state_r == ST_MULX || state_r == ST_SCANX) begin
      qry.lo = px_r;
      qry.size = w_r;
      qry.lead = px_r + w_r;
      qry.cross_lo = py_r;
      qry.cross_size = h_r;
    end else begin
      qry.lo = py_r;
      qry.size = h_r;
      qry.lead = py_r;
      qry.cross_lo = nx_r;
      qry.cross_size = w_r;
    end
  end

  aabb_scan #(.MAX_BOXES(MAX_BOXES), .IDX_W(IDX_W)) u_scan (
    .clk(clk), .rst_n(rst_n),
    .wr_en(ld_en), .wr_idx(IDX_W'(d[7:1])), .wr_keep(d[8]),
    .wr_x(d[32:9]), .wr_y(d[56:33]), .wr_w(d[76:57]), .wr_h(d[96:77]),
    .skip_slot(slot_r), .req(req), .qry(qry), .rsp(rsp)
  );

  function automatic logic signed [GeoW-1:0] sat24(input logic signed [GeoW-1:0] v);
    if (v > GeoW'(8388607)) sat24 = GeoW'(8388607);
    else if (v < -GeoW'(8388608)) sat24 = -GeoW'(8388608);
    else sat24 = v;
  endfunction

  logic signed [GeoW-1:0] stop_x, stop_y, npx, npy, vy_g;

  always_comb begin
    if (rsp.found) stop_x = rsp.stop;
    else if (vx_r > 0) stop_x = GeoW'(mapw_r);
    else stop_x = '0;
    if (rsp.found) stop_y = rsp.stop;
    else if (vy_r < 0) stop_y = GeoW'(maph_r);
    else stop_y = '0;
    npx = px_r + dx_r;
    npy = py_r - dy_r;
    vy_g = vy_r - floor_shr16(prod_r);
  end

  // Y velocity update happens between the gravity product and the Y product.
  assign vy_c = (vy_g < VyFloor) ? VyFloor : vy_g;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      slot_r <= d[7:1];
      px_r <= GeoW'($signed(d[32:9]));
      py_r <= GeoW'($signed(d[56:33]));
      w_r <= GeoW'(d[76:57]);
      h_r <= GeoW'(d[96:77]);
      vx_r <= GeoW'($signed(d[120:97]));
      vy_r <= GeoW'($signed(d[144:121]));
      mass_r <= d[160:145];
    end
    case (state_r)
      ST_SCANX: if (rsp.done) dx_r <= floor_shr16(prod_r);
      ST_RESX: begin
        if (vx_r > 0 && npx + w_r >= stop_x) begin
          nx_r <= sat24(stop_x - w_r);
          vx_r <= '0;
        end else if (vx_r < 0 && npx <= stop_x) begin
          nx_r <= sat24(stop_x);
          vx_r <= '0;
        end else begin
          nx_r <= sat24(npx);
        end
      end
      // prod_r holds g*ts here; apply gravity and clamp before the Y product.
      ST_GRAV: vy_r <= vy_c;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCANY && rsp.done) dy_r <= floor_shr16(prod_r);
    if (state_r == ST_RESY) begin
      if (vy_r < 0 && npy + h_r >= stop_y) begin
        airborne_r <= 1'b0;
        vyn_r <= '0;
        ny_r <= sat24(stop_y - h_r);
      end else if (vy_r > 0 && npy <= stop_y) begin
        airborne_r <= 1'b1;
        vyn_r <= '0;
        ny_r <= sat24(stop_y);
      end else begin
        airborne_r <= 1'b1;
        vyn_r <= vy_r;
        ny_r <= sat24(npy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      out_r <= {6'b0, (nx_r == px_r), airborne_r, vyn_r[23:0], vx_r[23:0],
                ny_r[23:0], nx_r[23:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accepting while result pending");
  a_out_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> out_tvalid) else $error("result not raised");
  a_scan_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == ST_SCANX || state_r == ST_SCANY))
    else $error("scan done outside scan state");

endmodule

@@ dv/tb_aabb_sweep_collision_step.sv @@
`timescale 1ns / 1ps

module tb_aabb_sweep_collision_step;
  import aabb_pkg::*;

  localparam int NumSlots = 64;
  localparam int IdleLimit = 12000;
  localparam int SettleCycles = 200;
  localparam int HoldCycles = 3000;

  // One input transaction, unpacked.
  typedef struct {
    bit               op;
    bit [6:0]         slot;
    bit               keep;
    bit signed [23:0] px;
    bit signed [23:0] py;
    bit [19:0]        w;
    bit [19:0]        h;
    bit signed [23:0] vx;
    bit signed [23:0] vy;
    bit [15:0]        mass;
  } box_item_t;

  // One result transaction, unpacked.
  typedef struct {
    bit signed [23:0] nx;
    bit signed [23:0] ny;
    bit signed [23:0] nvx;
    bit signed [23:0] nvy;
    bit               airborne;
    bit               x_stalled;
  } motion_t;

  // A row of the directed table: an item and, where it is obvious, its result.
  typedef struct {
    box_item_t item;
    bit        typed;
    motion_t   res;
  } directed_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CfgTimeStep;
  logic [22:0]  cfg_wdata = '0;

  aabb_sweep_collision_step uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's configuration and obstacle table.
  longint unsigned m_time_step, m_gravity, m_map_w, m_map_h;
  longint          obs_x[NumSlots], obs_y[NumSlots], obs_w[NumSlots], obs_h[NumSlots];
  bit              obs_valid[NumSlots];

  motion_t pending_motion[$];
  int      mismatches = 0;
  int      failures = 0;
  int      in_count = 0;
  int      out_count = 0;
  bit      hold_req = 1'b0;
  int      burst_left = 0;

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Updates the shadow table for a load, or works out the motion of a step.
  // Returns 1 when the item produces a result.
  function automatic bit predict_motion(input box_item_t it, output motion_t res);
    longint px, py, w, h, vx, vy, stop, np, nx, g;
    bit     found, air;
    int     i;
    px = longint'(it.px);
    py = longint'(it.py);
    w = longint'(it.w);
    h = longint'(it.h);
    vx = longint'(it.vx);
    vy = longint'(it.vy);
    res = '{default: 0};
    if (it.op == OpLoad) begin
      if (int'(it.slot) < NumSlots) begin
        obs_x[it.slot] = px;
        obs_y[it.slot] = py;
        obs_w[it.slot] = w;
        obs_h[it.slot] = h;
        obs_valid[it.slot] = it.keep;
      end
      return 1'b0;
    end

    // Horizontal sweep: nearest blocking edge among boxes overlapping on Y.
    stop = vx > 0 ? longint'(m_map_w) : (vx < 0 ? 0 : px + w);
    found = 1'b0;
    for (i = 0; i < NumSlots; i++) begin
      if (!obs_valid[i] || i == int'(it.slot)) continue;
      if (!(py + h > obs_y[i] && py < obs_y[i] + obs_h[i])) continue;
      if (vx > 0 && px + w <= obs_x[i]) begin
        if (!found || obs_x[i] < stop) stop = obs_x[i];
        found = 1'b1;
      end else if (vx < 0 && px >= obs_x[i] + obs_w[i]) begin
        if (!found || obs_x[i] + obs_w[i] > stop) stop = obs_x[i] + obs_w[i];
        found = 1'b1;
      end
    end
    np = px + ((vx * longint'(m_time_step)) >>> 16);
    if (vx > 0 && np + w >= stop) begin
      np = stop - w;
      vx = 0;
    end else if (vx < 0 && np <= stop) begin
      np = stop;
      vx = 0;
    end
    nx = clamp24(np);

    // Gravity pulls the upward velocity down, with a floor on the fall speed.
    g = longint'(m_gravity * it.mass) >>> 8;
    vy = vy - ((g * longint'(m_time_step)) >>> 16);
    if (vy < -384000) vy = -384000;

    // Vertical sweep against boxes overlapping the new X span.
    stop = vy < 0 ? longint'(m_map_h) : (vy > 0 ? 0 : py + h);
    found = 1'b0;
    for (i = 0; i < NumSlots; i++) begin
      if (!obs_valid[i] || i == int'(it.slot)) continue;
      if (!(nx + w > obs_x[i] && nx < obs_x[i] + obs_w[i])) continue;
      if (vy < 0 && py <= obs_y[i]) begin
        if (!found || obs_y[i] < stop) stop = obs_y[i];
        found = 1'b1;
      end else if (vy > 0 && py >= obs_y[i]) begin
        if (!found || obs_y[i] + obs_h[i] > stop) stop = obs_y[i] + obs_h[i];
        found = 1'b1;
      end
    end
    np = py - ((vy * longint'(m_time_step)) >>> 16);
    air = 1'b1;
    if (vy < 0 && np + h >= stop) begin
      air = 1'b0;
      vy = 0;
      np = stop - h;
    end else if (vy > 0 && np <= stop) begin
      vy = 0;
      np = stop;
    end

    res.nx = nx[23:0];
    res.ny = 24'(clamp24(np));
    res.nvx = vx[23:0];
    res.nvy = vy[23:0];
    res.airborne = air;
    res.x_stalled = (nx == px);
    return 1'b1;
  endfunction

  function automatic box_item_t mk_item(input bit op, input int slot, input bit keep,
                                        input int px, input int py, input int w,
                                        input int h, input int vx, input int vy,
                                        input int mass);
    box_item_t it;
    it.op = op;
    it.slot = 7'(slot);
    it.keep = keep;
    it.px = 24'(px);
    it.py = 24'(py);
    it.w = 20'(w);
    it.h = 20'(h);
    it.vx = 24'(vx);
    it.vy = 24'(vy);
    it.mass = 16'(mass);
    return it;
  endfunction

  // Offers one item, in bursts with random gaps in between. Called and left
  // at a falling edge; within a burst the valid stays high from one item to the next.
  task automatic offer_item(input box_item_t it, input bit typed, input motion_t typed_res);
    bit      taken;
    motion_t res;
    taken = 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata = {7'b0, it.mass, it.vy, it.vx, it.h, it.w, it.py, it.px,
                it.keep, it.slot, it.op};
    while (!taken) begin
      #1;
      taken = in_tready;
      @(posedge clk);
      if (taken) begin
        in_count++;
        if (predict_motion(it, res)) pending_motion.push_back(typed ? typed_res : res);
      end
      @(negedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (pending_motion.size() != 0) @(negedge clk);
    // Loads give no result; the block takes each one at its accepting edge.
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[22:0];
    case (idx)
      CfgTimeStep: m_time_step = 64'(value & 32'hFFFF);
      CfgGravity:  m_gravity = 64'(value & 32'hFFFF);
      CfgMapW:     m_map_w = 64'(value & 32'h7FFFFF);
      default:     m_map_h = 64'(value & 32'h7FFFFF);
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // A random obstacle or mover inside a small scene, so that contacts happen.
  function automatic box_item_t scene_item(input bit op);
    box_item_t it;
    it.op = op;
    it.keep = ($urandom_range(0, 7) != 0);
    it.slot = 7'(op == OpLoad ? $urandom_range(0, NumSlots - 1) : $urandom_range(0, NumSlots));
    it.px = 24'($urandom_range(0, 65535));
    it.py = 24'($urandom_range(0, 65535));
    it.w = 20'($urandom_range(256, 8192));
    it.h = 20'($urandom_range(256, 8192));
    it.vx = 24'($urandom_range(0, 4) == 0 ? 0 : int'($urandom_range(0, 2097151)) - 1048576);
    it.vy = 24'($urandom_range(0, 4) == 0 ? 0 : int'($urandom_range(0, 2097151)) - 1048576);
    it.mass = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024));
    return it;
  endfunction

  function automatic box_item_t noise_item;
    box_item_t it;
    it.op = 1'($urandom);
    it.slot = 7'($urandom);
    it.keep = 1'($urandom);
    it.px = 24'($urandom);
    it.py = 24'($urandom);
    it.w = 20'($urandom);
    it.h = 20'($urandom);
    it.vx = 24'($urandom);
    it.vy = 24'($urandom);
    it.mass = 16'($urandom);
    return it;
  endfunction

  // Mostly scenes: a few loads then several steps through them; the rest noise.
  task automatic random_items(input int count);
    int      n;
    motion_t none;
    none = '{default: 0};
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(1, 6)) begin
          offer_item(scene_item(OpLoad), 1'b0, none);
          n++;
        end
        repeat ($urandom_range(2, 8)) begin
          offer_item(scene_item(OpStep), 1'b0, none);
          n++;
        end
      end else begin
        offer_item(noise_item(), 1'b0, none);
        n++;
      end
    end
  endtask

  // Receiver: stalls on a pattern in randomly chosen modes, plus one long
  // hold-off when asked. Accepts are judged after the falling edge, once the
  // driven ready has settled.
  initial begin : result_sink
    int      mode, left;
    motion_t got, want;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = 1'($urandom_range(0, 1));
        2: out_tready = ($urandom_range(0, 4) == 0);
        default: out_tready = (left % 7) < 3;
      endcase
      #1;
      if (out_tvalid && out_tready) begin
        got.nx = out_tdata[23:0];
        got.ny = out_tdata[47:24];
        got.nvx = out_tdata[71:48];
        got.nvy = out_tdata[95:72];
        got.airborne = out_tdata[96];
        got.x_stalled = out_tdata[97];
        @(posedge clk);
        out_count++;
        if (pending_motion.size() == 0) begin
          failures++;
          if (mismatches < 10) $display("Unexpected result transaction: %p", got);
          mismatches++;
        end else begin
          want = pending_motion.pop_front();
          if (got != want) begin
            failures++;
            if (mismatches < 10) $display("Mismatch: expected %p, got %p", want, got);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int idle, last_in, last_out;
    idle = 0;
    last_in = 0;
    last_out = 0;
    forever begin
      @(posedge clk);
      #2;
      if (in_count != last_in || out_count != last_out || !rst_n) idle = 0;
      else idle++;
      last_in = in_count;
      last_out = out_count;
      if (idle >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  directed_row_t directed[$];

  initial begin : stimulus
    directed_row_t row;
    motion_t       none;
    none = '{default: 0};
    m_time_step = 1092;
    m_gravity = 2509;
    m_map_w = 262144;
    m_map_h = 196608;
    foreach (obs_valid[i]) begin
      obs_valid[i] = 1'b0;
      obs_x[i] = 0;
      obs_y[i] = 0;
      obs_w[i] = 0;
      obs_h[i] = 0;
    end

    // Still box, massless, empty table: nothing moves.
    row.item = mk_item(OpStep, 64, 0, 1000, 2000, 256, 256, 0, 0, 0);
    row.typed = 1'b1;
    row.res = '{nx: 1000, ny: 2000, nvx: 0, nvy: 0, airborne: 1, x_stalled: 1};
    directed.push_back(row);
    row.typed = 1'b0;
    // Loads: an obstacle, the top slot, out-of-range slots ignored, a clear.
    row.item = mk_item(OpLoad, 0, 1, 12800, 0, 2560, 25600, 0, 0, 0);
    directed.push_back(row);
    row.item = mk_item(OpLoad, 63, 1, 0, 40000, 65536, 2560, 0, 0, 0);
    directed.push_back(row);
    row.item = mk_item(OpLoad, 64, 1, 5000, 5000, 100, 100, 0, 0, 0);
    directed.push_back(row);
    row.item = mk_item(OpLoad, 127, 1, 5000, 5000, 100, 100, 0, 0, 0);
    directed.push_back(row);
    row.item = mk_item(OpLoad, 5, 1, 3000, 3000, 500, 500, 0, 0, 0);
    directed.push_back(row);
    row.item = mk_item(OpLoad, 5, 0, 3000, 3000, 500, 500, 0, 0, 0);
    directed.push_back(row);
    // Steps: into the wall on the right, from the right, with its own slot
    // skipped, landing on the floor box, flying up to the top edge, into the left edge.
    row.item = mk_item(OpStep, 64, 0, 10000, 5000, 2048, 2048, 500000, 0, 256);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, 16000, 5000, 2048, 2048, -500000, 0, 256);
    directed.push_back(row);
    row.item = mk_item(OpStep, 0, 0, 10000, 5000, 2048, 2048, 500000, 0, 256);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, 1000, 37000, 2048, 2048, 0, -300000, 256);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, 1000, 200, 2048, 2048, 0, 300000, 0);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, 200, 1000, 2048, 2048, -300000, 0, 0);
    directed.push_back(row);
    // Field extremes.
    row.item = mk_item(OpStep, 127, 1, 8388607, 8388607, 1048575, 1048575,
                       8388607, 8388607, 65535);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, -8388608, -8388608, 0, 0,
                       -8388608, -8388608, 65535);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, 0, 0, 1048575, 0, 8388607, -8388608, 0);
    directed.push_back(row);
    row.item = mk_item(OpStep, 64, 0, 260000, 190000, 0, 1048575, 0, 0, 65535);
    directed.push_back(row);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) offer_item(directed[i].item, directed[i].typed, directed[i].res);
    random_items(250);
    drain();

    // Largest settings; the long receiver hold makes the block back up.
    write_reg(CfgTimeStep, 65535);
    write_reg(CfgGravity, 65535);
    write_reg(CfgMapW, 8388607);
    write_reg(CfgMapH, 8388607);
    hold_req = 1'b1;
    random_items(270);
    drain();

    // Zero settings: velocities give no displacement and every map edge sits at the origin.
    write_reg(CfgTimeStep, 0);
    write_reg(CfgGravity, 0);
    write_reg(CfgMapW, 0);
    write_reg(CfgMapH, 0);
    random_items(200);
    drain();

    // Random settings, with a fast frame so that contacts are common.
    write_reg(CfgTimeStep, $urandom_range(1000, 20000));
    write_reg(CfgGravity, $urandom);
    write_reg(CfgMapW, $urandom_range(65536, 300000));
    write_reg(CfgMapH, $urandom_range(65536, 300000));
    random_items(360);
    drain();

    failures += pending_motion.size();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/aabb_pkg.sv
design/aabb_scan.sv
design/aabb_sweep_collision_step.sv
dv/tb_aabb_sweep_collision_step.sv
